### sv/radar_frame_parser_core_assert.svh
// Assertion macros used by the frame parser checker.
`ifndef RADAR_FRAME_PARSER_CORE_ASSERT_SVH
`define RADAR_FRAME_PARSER_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define RFP_ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication built on the clocked form.
`define RFP_IMPLIES(lbl, ante, cons, msg) \
  `RFP_ASSERT_AT(lbl, (ante) |-> (cons), msg)

`endif

### sv/rfp_pkg.sv
// Shared constants, codes and types of the frame parser.
`timescale 1ns / 1ps
package rfp_pkg;

  localparam int MAX_PAYLOAD  = 64;
  localparam int HEADER_BYTES = 8;
  localparam int POS_W        = 7;
  localparam int IDX_W        = $clog2(MAX_PAYLOAD);
  localparam int RAM_DEPTH    = 2 * MAX_PAYLOAD;
  localparam int RAM_AW       = $clog2(RAM_DEPTH);
  localparam int CMD_DEPTH    = 2;
  localparam int M_TDATA_W    = 96;
  localparam int M_TUSER_W    = 3;

  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_HDR_CSUM = 2'd1;
  localparam logic [1:0] ST_LEN_BIG  = 2'd2;
  localparam logic [1:0] ST_DAT_CSUM = 2'd3;

  // One finished frame, handed from the parser to the readout side.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] frame_type;
    logic [6:0]  plen;
    logic        has_data;
    logic        bank;
    logic [6:0]  cnt;
    logic [31:0] good;
    logic [31:0] bad;
  } cmd_t;

  // Readout side gives a payload bank back to the parser.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

### sv/rfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/rfp_cmd_fifo.sv
// Short queue of finished-frame commands between parser and readout.
`timescale 1ns / 1ps
module rfp_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rfp_pkg::cmd_t push_cmd,
  input  logic          pop,
  output rfp_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import rfp_pkg::*;

  localparam int PW = $clog2(CMD_DEPTH);
  localparam int CW = $clog2(CMD_DEPTH + 1);

  cmd_t          mem [CMD_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(CMD_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### sv/rfp_front.sv
// Frame parser: hunts, checks the header, stores the payload, queues results.
`timescale 1ns / 1ps
module rfp_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [7:0]                   cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,
  input  logic                         fifo_full,
  output logic                         push,
  output rfp_pkg::cmd_t                push_cmd,
  output logic                         ram_we,
  output logic [rfp_pkg::RAM_AW-1:0]   ram_waddr,
  output logic [7:0]                   ram_wdata,
  input  rfp_pkg::rel_t                rel
);
  import rfp_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_HEAD = 4'b0010,
    PH_DATA = 4'b0100,
    PH_CSUM = 4'b1000
  } phase_t;

  phase_t            phase, phase_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [7:0]        hxor, hxor_next;
  logic [7:0]        dxor, dxor_next;
  logic [15:0]       length_reg, length_reg_next;
  logic [15:0]       type_reg, type_reg_next;
  logic [31:0]       good_count, good_count_next;
  logic [31:0]       bad_count, bad_count_next;
  logic              wr_bank, wr_bank_next;
  logic [1:0]        busy, busy_next;
  logic [7:0]        start_byte;

  logic              accept;
  logic              hdr_last;
  logic [POS_W-1:0]  pos_inc;
  logic              claim_bank;

  assign cfg_ready = 1'b1;
  assign hdr_last  = (pos == POS_W'(HEADER_BYTES - 1));
  assign pos_inc   = pos + POS_W'(1);

  // Hold off a payload byte while its bank is still being read out, and the last
  // header byte or the checksum byte while the queue has no room for a result.
  assign s_tready = !((phase == PH_DATA) && busy[wr_bank]) &&
                    !(fifo_full && (((phase == PH_HEAD) && hdr_last) || (phase == PH_CSUM)));
  assign accept   = s_tvalid && s_tready;

  assign ram_waddr = {wr_bank, pos[IDX_W-1:0]};
  assign ram_wdata = s_tdata;

  always_comb begin
    phase_next      = phase;
    pos_next        = pos;
    hxor_next       = hxor;
    dxor_next       = dxor;
    length_reg_next = length_reg;
    type_reg_next   = type_reg;
    good_count_next = good_count;
    bad_count_next  = bad_count;
    wr_bank_next    = wr_bank;
    claim_bank      = 1'b0;
    push            = 1'b0;
    ram_we          = 1'b0;

    push_cmd.status     = ST_GOOD;
    push_cmd.frame_type = type_reg;
    push_cmd.plen       = (length_reg > 16'd127) ? 7'd127 : length_reg[6:0];
    push_cmd.has_data   = 1'b0;
    push_cmd.bank       = wr_bank;
    push_cmd.cnt        = length_reg[6:0];
    push_cmd.good       = good_count;
    push_cmd.bad        = bad_count;

    unique case (phase)
      PH_HUNT: begin
        if (accept && (s_tdata == start_byte)) begin
          hxor_next       = s_tdata;
          pos_next        = POS_W'(1);
          length_reg_next = '0;
          type_reg_next   = '0;
          phase_next      = PH_HEAD;
        end
      end
      PH_HEAD: begin
        if (accept) begin
          if (!hdr_last) begin
            hxor_next = hxor ^ s_tdata;
            case (pos)
              POS_W'(3): length_reg_next[15:8] = s_tdata;
              POS_W'(4): length_reg_next[7:0]  = s_tdata;
              POS_W'(5): type_reg_next[15:8]   = s_tdata;
              POS_W'(6): type_reg_next[7:0]    = s_tdata;
              default:   ;
            endcase
            pos_next = pos_inc;
          end else begin
            phase_next = PH_HUNT;
            if (~hxor != s_tdata) begin
              bad_count_next  = bad_count + 32'd1;
              push            = 1'b1;
              push_cmd.status = ST_HDR_CSUM;
              push_cmd.bad    = bad_count + 32'd1;
            end else if (length_reg > 16'(MAX_PAYLOAD)) begin
              bad_count_next  = bad_count + 32'd1;
              push            = 1'b1;
              push_cmd.status = ST_LEN_BIG;
              push_cmd.bad    = bad_count + 32'd1;
            end else begin
              dxor_next  = '0;
              pos_next   = '0;
              phase_next = (length_reg == '0) ? PH_CSUM : PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        if (accept) begin
          ram_we    = 1'b1;
          dxor_next = dxor ^ s_tdata;
          pos_next  = pos_inc;
          if ({9'd0, pos_inc} >= length_reg) begin
            phase_next = PH_CSUM;
          end
        end
      end
      PH_CSUM: begin
        if (accept) begin
          phase_next = PH_HUNT;
          push       = 1'b1;
          if (~dxor != s_tdata) begin
            bad_count_next  = bad_count + 32'd1;
            push_cmd.status = ST_DAT_CSUM;
            push_cmd.bad    = bad_count + 32'd1;
          end else begin
            good_count_next   = good_count + 32'd1;
            push_cmd.good     = good_count + 32'd1;
            push_cmd.has_data = (length_reg != '0);
            if (length_reg != '0) begin
              claim_bank   = 1'b1;
              wr_bank_next = ~wr_bank;
            end
          end
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase

    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (claim_bank) begin
      busy_next[wr_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      pos        <= '0;
      hxor       <= '0;
      dxor       <= '0;
      length_reg <= '0;
      type_reg   <= '0;
      good_count <= '0;
      bad_count  <= '0;
      wr_bank    <= 1'b0;
      busy       <= '0;
      start_byte <= 8'd1;
    end else begin
      phase      <= phase_next;
      pos        <= pos_next;
      hxor       <= hxor_next;
      dxor       <= dxor_next;
      length_reg <= length_reg_next;
      type_reg   <= type_reg_next;
      good_count <= good_count_next;
      bad_count  <= bad_count_next;
      wr_bank    <= wr_bank_next;
      busy       <= busy_next;
      if (cfg_valid) begin
        start_byte <= cfg_data;
      end
    end
  end

endmodule

### sv/rfp_back.sv
// Readout: turns queued frame commands into status items or payload byte items.
`timescale 1ns / 1ps
module rfp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fifo_empty,
  input  rfp_pkg::cmd_t                 head,
  output logic                          pop,
  output logic [rfp_pkg::RAM_AW-1:0]    ram_raddr,
  input  logic [7:0]                    ram_rdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rfp_pkg::M_TDATA_W-1:0] m_tdata,
  output logic [rfp_pkg::M_TUSER_W-1:0] m_tuser,
  output logic                          m_tlast,
  output rfp_pkg::rel_t                 rel
);
  import rfp_pkg::*;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'b001,
    BK_FETCH = 3'b010,
    BK_SHOW  = 3'b100
  } bk_state_t;

  bk_state_t        state;
  cmd_t             cur;
  logic [IDX_W-1:0] idx;
  logic [7:0]       o_byte;
  logic             o_bval;
  logic             o_last;
  logic             is_last_byte;
  logic             take;

  assign pop          = (state == BK_IDLE) && !fifo_empty;
  assign take         = (state == BK_SHOW) && m_tready;
  assign is_last_byte = (({1'b0, idx} + 7'd1) == cur.cnt);
  assign ram_raddr    = (state == BK_IDLE) ? {head.bank, {IDX_W{1'b0}}}
                                           : {cur.bank, idx + IDX_W'(1)};

  assign rel.valid = take && o_last && cur.has_data;
  assign rel.bank  = cur.bank;

  assign m_tvalid = (state == BK_SHOW);
  assign m_tlast  = o_last;
  assign m_tuser  = {o_bval, cur.status};
  assign m_tdata  = {1'b0, cur.bad, cur.good, o_byte, cur.plen, cur.frame_type};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      unique case (state)
        BK_IDLE: begin
          if (pop) begin
            state <= head.has_data ? BK_FETCH : BK_SHOW;
          end
        end
        BK_FETCH: begin
          state <= BK_SHOW;
        end
        BK_SHOW: begin
          if (take) begin
            state <= o_last ? BK_IDLE : BK_FETCH;
          end
        end
        default: begin
          state <= BK_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur    <= head;
      idx    <= '0;
      o_byte <= '0;
      o_bval <= 1'b0;
      o_last <= 1'b1;
    end else if (state == BK_FETCH) begin
      o_byte <= ram_rdata;
      o_bval <= 1'b1;
      o_last <= is_last_byte;
    end else if (take && !o_last) begin
      idx <= idx + IDX_W'(1);
    end
  end

endmodule

### sv/radar_frame_parser_core.sv
// Top level of the byte-stream frame parser with inverted-XOR header and data checksums.
// A status item passes the command queue and the readout state register after the byte
// that closes its frame; the first payload item also waits for the registered RAM read.
// The parser takes one byte per cycle while s_tready is high; each payload item passes
// BK_FETCH for the registered RAM read, and the next byte is read only after it is taken.
// Reset: synchronous rst clears parser state, counters, queue and start byte (to 1);
// the payload RAM keeps its contents and needs no clearing.
`timescale 1ns / 1ps
module radar_frame_parser_core (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration: start-of-frame byte value.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [7:0]                    cfg_data,
  // Received bytes in.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
  // Result items out.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [15:0] frame_type, [22:16] payload_len, [30:23] payload_byte,
  // [62:31] good_frames, [94:63] bad_frames, [95] zero
  output logic [rfp_pkg::M_TDATA_W-1:0] m_tdata,
  // [1:0] status, [2] byte_valid
  output logic [rfp_pkg::M_TUSER_W-1:0] m_tuser,
  output logic                          m_tlast
);
  import rfp_pkg::*;

  // The parser (front) and the readout (back) meet at a two-entry command
  // queue. The payload RAM holds two banks of MAX_PAYLOAD bytes, so the parser
  // can fill one frame while the readout still streams out the previous one.
  // A bank is claimed when a good frame with payload is queued and given back
  // when its last byte item has been taken.

  logic              push;
  cmd_t              push_cmd;
  logic              pop;
  cmd_t              head;
  logic              fifo_full;
  logic              fifo_empty;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [RAM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  rel_t              rel;

  rfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .fifo_full (fifo_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .rel       (rel)
  );

  rfp_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  rfp_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_empty (fifo_empty),
    .head       (head),
    .pop        (pop),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .rel        (rel)
  );

endmodule

### sv/rfp_checker.sv
// Port-level checks of the frame parser, bound to the top level.
`timescale 1ns / 1ps
`include "radar_frame_parser_core_assert.svh"
module rfp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rfp_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [rfp_pkg::M_TUSER_W-1:0] m_tuser,
  input logic                          m_tlast
);
  import rfp_pkg::*;

  // A stalled item stays offered.
  `RFP_ASSERT_AT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "item dropped while stalled")
  // A status-only item always closes its run.
  `RFP_IMPLIES(a_status_last, m_tvalid && !m_tuser[2], m_tlast, "status item without last")
  // Payload bytes come only from good frames.
  `RFP_IMPLIES(a_byte_good, m_tvalid && m_tuser[2], m_tuser[1:0] == ST_GOOD, "byte on bad frame")
  // A status-only item carries a zero payload byte.
  `RFP_IMPLIES(a_status_zero, m_tvalid && !m_tuser[2], m_tdata[30:23] == 8'd0, "status byte not zero")

endmodule

bind radar_frame_parser_core rfp_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
